FILE: hw/rtl/ipv4fhg_pkg.sv
// Package for the IPv4 fragment header generator.
// Holds the shared constants, sequencer state type and descriptor struct.
// No dependencies.
package ipv4fhg_pkg;

    localparam int MTU_DEFAULT    = 1500;
    localparam int IPV4_HDR_BYTES = 20;
    localparam int MAX_FRAGS      = 45;

    localparam logic [15:0] IPV4_VER_IHL_WORD = 16'h4500;
    localparam logic [7:0]  TTL_RESET         = 8'd64;

    // Register word index (byte address bit 2)
    localparam logic REG_SOURCE_IP = 1'b0;
    localparam logic REG_TTL       = 1'b1;

    // Fixed header words summed once per datagram, in step order
    localparam logic [2:0] STEP_IDENT   = 3'd0;
    localparam logic [2:0] STEP_TTL_PRO = 3'd1;
    localparam logic [2:0] STEP_SRC_HI  = 3'd2;
    localparam logic [2:0] STEP_SRC_LO  = 3'd3;
    localparam logic [2:0] STEP_DST_HI  = 3'd4;
    localparam logic [2:0] STEP_DST_LO  = 3'd5;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_BASE,
        ST_TLEN,
        ST_FLAGS
    } t_state;

    typedef struct packed {
        logic [10:0] total_length;
        logic [15:0] ident;
        logic        more_fragments;
        logic        dont_fragment;
        logic [12:0] fragment_offset;
        logic [15:0] payload_start;
        logic [15:0] header_checksum;
        logic        last;
    } t_desc;

endpackage

FILE: hw/rtl/ipv4_fragment_header_generator.sv
// A request first sums the fixed header words (ST_BASE); each fragment then
// takes two adds on the shared checksum adder (ST_TLEN, ST_FLAGS), stalling
// in ST_FLAGS while the output register is full. A new request waits until
// the last descriptor is loaded; an oversize one is accepted and dropped.
// Reset is synchronous, active low: identifier 0, source_ip 0, time_to_live
// 64, no descriptor pending. Uses ipv4fhg_pkg, ipv4fhg_seq, ipv4fhg_ocadd.
module ipv4_fragment_header_generator #(
    parameter int MTU_BYTES = ipv4fhg_pkg::MTU_DEFAULT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // APB register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // Request channel
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [15:0] i_payload_length,
    input  logic [7:0]  i_protocol,
    input  logic [31:0] i_dest_ip,
    // Descriptor channel
    output logic        o_valid,
    input  logic        i_ready,
    output logic [10:0] o_total_length,
    output logic [15:0] o_ident,
    output logic        o_more_fragments,
    output logic        o_dont_fragment,
    output logic [12:0] o_fragment_offset,
    output logic [15:0] o_payload_start,
    output logic [15:0] o_header_checksum,
    output logic        o_last
);
    import ipv4fhg_pkg::*;

    logic [31:0] r_source_ip;
    logic [7:0]  r_ttl;
    logic        w_wr;
    t_desc       w_desc;

    // Register writes complete in the access phase; pready never stalls.
    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && pready;

    // Decode on the word index only; low address bits are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_source_ip <= 32'd0;
            r_ttl       <= TTL_RESET;
        end else if (w_wr) begin
            unique case (paddr[2])
                REG_SOURCE_IP: r_source_ip <= pwdata;
                REG_TTL:       r_ttl       <= pwdata[7:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_SOURCE_IP: prdata = r_source_ip;
            REG_TTL:       prdata = {24'd0, r_ttl};
            default:       prdata = 32'd0;
        endcase
    end

    // Sequencer: takes one request beat, then emits its fragment descriptors
    // through a one-deep output register while it computes the next one.
    ipv4fhg_seq #(
        .MTU_BYTES (MTU_BYTES)
    ) u_seq (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_source_ip      (r_source_ip),
        .i_time_to_live   (r_ttl),
        .i_in_valid       (i_valid),
        .o_in_ready       (o_ready),
        .i_payload_length (i_payload_length),
        .i_protocol       (i_protocol),
        .i_dest_ip        (i_dest_ip),
        .o_out_valid      (o_valid),
        .i_out_ready      (i_ready),
        .o_desc           (w_desc)
    );

    // Unpack the descriptor beat onto the field ports.
    assign o_total_length    = w_desc.total_length;
    assign o_ident           = w_desc.ident;
    assign o_more_fragments  = w_desc.more_fragments;
    assign o_dont_fragment   = w_desc.dont_fragment;
    assign o_fragment_offset = w_desc.fragment_offset;
    assign o_payload_start   = w_desc.payload_start;
    assign o_header_checksum = w_desc.header_checksum;
    assign o_last            = w_desc.last;

`ifndef SYNTH
    // An unfragmented datagram is a single beat at offset zero.
    a_df_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_dont_fragment |-> o_last && (o_fragment_offset == 13'd0))
        else $error("DF set on a non-final or offset descriptor");

    // MF marks every descriptor but the last.
    a_mf_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_more_fragments != o_last))
        else $error("MF and last disagree");

    // No new request while a datagram still has descriptors to deliver.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last |-> !o_ready)
        else $error("request accepted mid-datagram");

    // Fragment length stays within header size and MTU.
    a_tlen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_total_length >= 11'd20) && (o_total_length <= 11'(MTU_BYTES)))
        else $error("total length out of range");
`endif

endmodule

FILE: hw/rtl/ipv4fhg_ocadd.sv
// One's-complement 16-bit adder with end-around carry.
// Shared checksum unit of the sequencer; depends on nothing.
module ipv4fhg_ocadd (
    input  logic [15:0] i_a,
    input  logic [15:0] i_b,
    output logic [15:0] o_sum
);

    logic [16:0] w_raw;

    assign w_raw = {1'b0, i_a} + {1'b0, i_b};
    assign o_sum = w_raw[15:0] + {15'd0, w_raw[16]};

endmodule

FILE: hw/rtl/ipv4fhg_seq.sv
// Fragment sequencer: walks the payload one fragment at a time and
// builds each descriptor through the shared adder. Uses ipv4fhg_pkg, ipv4fhg_ocadd.
module ipv4fhg_seq #(
    parameter int MTU_BYTES = ipv4fhg_pkg::MTU_DEFAULT
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [31:0]         i_source_ip,
    input  logic [7:0]          i_time_to_live,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [15:0]         i_payload_length,
    input  logic [7:0]          i_protocol,
    input  logic [31:0]         i_dest_ip,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output ipv4fhg_pkg::t_desc  o_desc
);
    import ipv4fhg_pkg::*;

    localparam int CHUNK     = ((MTU_BYTES - IPV4_HDR_BYTES) / 8) * 8;
    localparam int LEN_LIMIT = MAX_FRAGS * CHUNK;

    t_state      r_state, n_state;
    logic [2:0]  r_step, n_step;
    logic [15:0] r_acc, n_acc;
    logic [15:0] r_base, n_base;
    logic [15:0] r_rem, n_rem;
    logic [15:0] r_start, n_start;
    logic        r_first, n_first;
    logic [7:0]  r_proto, n_proto;
    logic [31:0] r_dst, n_dst;
    logic [15:0] r_ident, n_ident;
    t_desc       r_out, n_out;
    logic        r_out_vld, n_out_vld;

    logic        w_refuse;
    logic        w_last;
    logic        w_out_free;
    logic [10:0] w_bytes;
    logic [10:0] w_tlen;
    logic [15:0] w_flags;
    logic [15:0] w_op_a, w_op_b, w_sum;

    ipv4fhg_ocadd u_add (
        .i_a   (w_op_a),
        .i_b   (w_op_b),
        .o_sum (w_sum)
    );

    assign w_refuse   = {16'd0, i_payload_length} > 32'(LEN_LIMIT);
    assign w_last     = r_rem <= 16'(CHUNK);
    assign w_out_free = !r_out_vld || i_out_ready;
    assign w_bytes    = w_last ? r_rem[10:0] : 11'(CHUNK);
    assign w_tlen     = w_bytes + 11'(IPV4_HDR_BYTES);
    assign w_flags    = {1'b0, r_first && w_last, !w_last, r_start[15:3]};

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_vld;
    assign o_desc      = r_out;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid && !w_refuse) n_state = ST_BASE;
            end
            ST_BASE: begin
                if (r_step == STEP_DST_LO) n_state = ST_TLEN;
            end
            ST_TLEN: n_state = ST_FLAGS;
            ST_FLAGS: begin
                if (w_out_free) n_state = w_last ? ST_IDLE : ST_TLEN;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Datapath and outputs
    always_comb begin
        n_step    = r_step;
        n_acc     = r_acc;
        n_base    = r_base;
        n_rem     = r_rem;
        n_start   = r_start;
        n_first   = r_first;
        n_proto   = r_proto;
        n_dst     = r_dst;
        n_ident   = r_ident;
        n_out     = r_out;
        n_out_vld = r_out_vld && !i_out_ready;
        w_op_a    = r_acc;
        w_op_b    = 16'd0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid && !w_refuse) begin
                    n_step  = STEP_IDENT;
                    n_acc   = IPV4_VER_IHL_WORD;
                    n_rem   = i_payload_length;
                    n_start = 16'd0;
                    n_first = 1'b1;
                    n_proto = i_protocol;
                    n_dst   = i_dest_ip;
                    n_ident = r_ident + 16'd1;
                end
            end
            ST_BASE: begin
                case (r_step)
                    STEP_IDENT:   w_op_b = r_ident;
                    STEP_TTL_PRO: w_op_b = {i_time_to_live, r_proto};
                    STEP_SRC_HI:  w_op_b = i_source_ip[31:16];
                    STEP_SRC_LO:  w_op_b = i_source_ip[15:0];
                    STEP_DST_HI:  w_op_b = r_dst[31:16];
                    default:      w_op_b = r_dst[15:0];
                endcase
                n_acc  = w_sum;
                n_base = w_sum;
                n_step = r_step + 3'd1;
            end
            ST_TLEN: begin
                w_op_a = r_base;
                w_op_b = {5'd0, w_tlen};
                n_acc  = w_sum;
            end
            ST_FLAGS: begin
                w_op_a = r_acc;
                w_op_b = w_flags;
                if (w_out_free) begin
                    n_out.total_length    = w_tlen;
                    n_out.ident           = r_ident;
                    n_out.more_fragments  = !w_last;
                    n_out.dont_fragment   = r_first && w_last;
                    n_out.fragment_offset = r_start[15:3];
                    n_out.payload_start   = r_start;
                    n_out.header_checksum = ~w_sum;
                    n_out.last            = w_last;
                    n_out_vld             = 1'b1;
                    n_rem                 = r_rem - 16'(CHUNK);
                    n_start               = r_start + 16'(CHUNK);
                    n_first               = 1'b0;
                end
            end
            default: begin
                n_out_vld = r_out_vld && !i_out_ready;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_ident   <= 16'd0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_ident   <= n_ident;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_step  <= n_step;
        r_acc   <= n_acc;
        r_base  <= n_base;
        r_rem   <= n_rem;
        r_start <= n_start;
        r_first <= n_first;
        r_proto <= n_proto;
        r_dst   <= n_dst;
        r_out   <= n_out;
    end

endmodule

FILE: tb/ipv4_fragment_header_generator_tb.sv
// Self-checking testbench for the IPv4 fragment header generator: directed
// table, then three random phases under different idling and register settings.
// Depends on ipv4fhg_pkg and the ipv4_fragment_header_generator RTL only.
module ipv4_fragment_header_generator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ipv4fhg_pkg::*;

    // Payload bytes carried by every fragment but the last: MTU less the
    // header, rounded down to a multiple of 8 so offsets stay in 8-byte units.
    localparam int FRAG_BYTES  = ((MTU_DEFAULT - IPV4_HDR_BYTES) / 8) * 8;
    localparam int STALL_LIMIT = 4000;
    localparam int DRAIN_WAIT  = 120;
    localparam int NUM_ROWS    = 17;

    typedef struct {
        logic [15:0] length;
        logic [7:0]  proto;
        logic [31:0] dst;
        bit          typed;
        t_desc       want;
    } t_stim_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        i_valid;
    logic        o_ready;
    logic [15:0] i_payload_length;
    logic [7:0]  i_protocol;
    logic [31:0] i_dest_ip;
    logic        o_valid;
    logic        i_ready;
    logic [10:0] o_total_length;
    logic [15:0] o_ident;
    logic        o_more_fragments;
    logic        o_dont_fragment;
    logic [12:0] o_fragment_offset;
    logic [15:0] o_payload_start;
    logic [15:0] o_header_checksum;
    logic        o_last;

    // Shadow copy of the block's registers and identifier
    logic [31:0] shadow_src_ip;
    logic [7:0]  shadow_ttl;
    logic [15:0] shadow_ident;

    t_desc       expected_headers[$];
    t_desc       got_header;
    t_desc       want_header;
    t_stim_row   directed_rows[NUM_ROWS];

    int          mismatch_count;
    int          stall_cycles;
    int          send_idle_pct;
    int          recv_idle_pct;

    ipv4_fragment_header_generator dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_payload_length  (i_payload_length),
        .i_protocol        (i_protocol),
        .i_dest_ip         (i_dest_ip),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_total_length    (o_total_length),
        .o_ident           (o_ident),
        .o_more_fragments  (o_more_fragments),
        .o_dont_fragment   (o_dont_fragment),
        .o_fragment_offset (o_fragment_offset),
        .o_payload_start   (o_payload_start),
        .o_header_checksum (o_header_checksum),
        .o_last            (o_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // One's-complement checksum over the nine header words, using the
    // shadow source address and TTL.
    function automatic logic [15:0] ones_checksum(input logic [10:0] tlen,
                                                  input logic [15:0] id,
                                                  input logic [15:0] flag_word,
                                                  input logic [7:0]  proto,
                                                  input logic [31:0] dst);
        logic [31:0] acc;
        acc = 32'(IPV4_VER_IHL_WORD) + 32'(tlen) + 32'(id) + 32'(flag_word)
            + 32'({shadow_ttl, proto})
            + 32'(shadow_src_ip[31:16]) + 32'(shadow_src_ip[15:0])
            + 32'(dst[31:16]) + 32'(dst[15:0]);
        while (acc > 32'hFFFF)
            acc = 32'(acc[15:0]) + 32'(acc[31:16]);
        return ~acc[15:0];
    endfunction

    // Split one datagram into fragments and queue a header per fragment.
    // Bump the identifier first; a refused datagram leaves it alone.
    function automatic void forecast_datagram(input logic [15:0] length,
                                              input logic [7:0]  proto,
                                              input logic [31:0] dst);
        int unsigned count;
        int unsigned start;
        int unsigned bytes;
        logic        mf;
        logic        df;
        logic [15:0] flag_word;
        t_desc       hdr;
        count = (int'(length) + FRAG_BYTES - 1) / FRAG_BYTES;
        if (count == 0)
            count = 1;
        if (count > MAX_FRAGS)
            return;
        shadow_ident = shadow_ident + 16'd1;
        for (int unsigned i = 0; i < count; i++) begin
            start = i * FRAG_BYTES;
            bytes = (i + 1 == count) ? int'(length) - start : FRAG_BYTES;
            mf    = (i + 1 != count);
            df    = (count == 1);
            flag_word = {1'b0, df, mf, 13'(start >> 3)};
            hdr.total_length    = 11'(bytes + IPV4_HDR_BYTES);
            hdr.ident           = shadow_ident;
            hdr.more_fragments  = mf;
            hdr.dont_fragment   = df;
            hdr.fragment_offset = 13'(start >> 3);
            hdr.payload_start   = 16'(start);
            hdr.header_checksum = ones_checksum(hdr.total_length, shadow_ident,
                                                flag_word, proto, dst);
            hdr.last            = !mf;
            expected_headers.push_back(hdr);
        end
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    task automatic flag_mismatch(input string what, input longint got,
                                 input longint want);
        $display("%0t ns: mismatch on %s: got 0x%0h, expected 0x%0h",
                 $time, what, got, want);
        mismatch_count++;
    endtask

    task automatic compare_header(input t_desc got, input t_desc want);
        if (got.total_length !== want.total_length)
            flag_mismatch("total_length", got.total_length, want.total_length);
        if (got.ident !== want.ident)
            flag_mismatch("ident", got.ident, want.ident);
        if (got.more_fragments !== want.more_fragments)
            flag_mismatch("more_fragments", got.more_fragments, want.more_fragments);
        if (got.dont_fragment !== want.dont_fragment)
            flag_mismatch("dont_fragment", got.dont_fragment, want.dont_fragment);
        if (got.fragment_offset !== want.fragment_offset)
            flag_mismatch("fragment_offset", got.fragment_offset,
                          want.fragment_offset);
        if (got.payload_start !== want.payload_start)
            flag_mismatch("payload_start", got.payload_start, want.payload_start);
        if (got.header_checksum !== want.header_checksum)
            flag_mismatch("header_checksum", got.header_checksum,
                          want.header_checksum);
        if (got.last !== want.last)
            flag_mismatch("last", got.last, want.last);
    endtask

    // Descriptor side: randomly stall, check every accepted beat against the
    // oldest queued header, and run the no-progress watchdog. Sampling here
    // sees the pre-edge values, so the result does not hinge on event order.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
            stall_cycles = 0;
        end else begin
            i_ready <= ($urandom_range(99) >= recv_idle_pct);
            if (o_valid && i_ready) begin
                got_header = '{o_total_length, o_ident, o_more_fragments,
                               o_dont_fragment, o_fragment_offset,
                               o_payload_start, o_header_checksum, o_last};
                if (expected_headers.size() == 0) begin
                    flag_mismatch("unexpected descriptor ident", o_ident, 0);
                end else begin
                    want_header = expected_headers.pop_front();
                    compare_header(got_header, want_header);
                end
            end
            // Any handshake on any channel counts as progress
            if ((o_valid && i_ready) || (i_valid && o_ready) || (psel && penable))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("ipv4_fragment_header_generator_tb: FAIL");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Register port
    // ------------------------------------------------------------------

    // Write a register with a setup and an access phase, mirror it in the
    // shadow copy, then read it back.
    task automatic set_register(input logic reg_idx, input logic [31:0] value);
        logic [31:0] readback;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (reg_idx == REG_SOURCE_IP)
            shadow_src_ip = value;
        else
            shadow_ttl = value[7:0];
        // Read back: setup, then sample prdata at the access edge
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        readback = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (reg_idx == REG_SOURCE_IP && readback !== shadow_src_ip)
            flag_mismatch("source_ip readback", readback, shadow_src_ip);
        if (reg_idx == REG_TTL && readback[7:0] !== shadow_ttl)
            flag_mismatch("time_to_live readback", readback[7:0], shadow_ttl);
        // Return the port to idle before the next transfer
        @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------

    // Present one request beat, hold it until accepted, then queue what it
    // should produce. A typed row supplies its single header directly.
    task automatic send_request(input logic [15:0] length, input logic [7:0] proto,
                                input logic [31:0] dst, input bit typed,
                                input t_desc want);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid          <= 1'b1;
        i_payload_length <= length;
        i_protocol       <= proto;
        i_dest_ip        <= dst;
        do @(posedge i_clk); while (!o_ready);
        if (typed) begin
            shadow_ident = shadow_ident + 16'd1;
            expected_headers.push_back(want);
        end else begin
            forecast_datagram(length, proto, dst);
        end
    endtask

    // Mostly short datagrams; a share sits right at the fragment boundaries,
    // and a few span the whole 16-bit length range.
    function automatic logic [15:0] pick_length();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 40)
            return 16'($urandom_range(FRAG_BYTES));
        else if (roll < 70)
            return 16'($urandom_range(6000, FRAG_BYTES + 1));
        else if (roll < 85)
            return 16'($urandom_range(MAX_FRAGS - 1, 1) * FRAG_BYTES
                       + $urandom_range(2) - 1);
        else
            return 16'($urandom_range(16'hFFFF));
    endfunction

    task automatic run_random(input int snd_pct, input int rcv_pct, input int items);
        send_idle_pct = snd_pct;
        recv_idle_pct = rcv_pct;
        for (int n = 0; n < items; n++)
            send_request(pick_length(), 8'($urandom_range(255)), $urandom, 1'b0, '0);
        i_valid <= 1'b0;
    endtask

    // Let every queued header arrive, then give the block time to go idle
    // before the registers change.
    task automatic drain(input int extra);
        while (expected_headers.size() != 0)
            @(posedge i_clk);
        repeat (extra) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------

    initial begin
        // Directed table. The first two rows follow reset directly, so their
        // single headers can be written out by hand: identifiers 1 and 2,
        // source address 0 and TTL 64.
        directed_rows = '{
            '{16'd0,     8'd0,   32'h0000_0000, 1'b1,
              '{11'd20,   16'd1, 1'b0, 1'b1, 13'd0, 16'd0, 16'h3AEA, 1'b1}},
            '{16'd1480,  8'd255, 32'hFFFF_FFFF, 1'b1,
              '{11'd1500, 16'd2, 1'b0, 1'b1, 13'd0, 16'd0, 16'h3422, 1'b1}},
            '{16'd1,     8'd6,   32'hC0A8_0001, 1'b0, '0},
            '{16'd7,     8'd17,  32'h0A00_0001, 1'b0, '0},
            '{16'd8,     8'd1,   32'hAAAA_AAAA, 1'b0, '0},
            '{16'd1479,  8'd128, 32'h5555_5555, 1'b0, '0},
            // one byte past a single fragment
            '{16'd1481,  8'd127, 32'h8000_0000, 1'b0, '0},
            '{16'd2960,  8'd6,   32'h0000_0001, 1'b0, '0},
            '{16'd2961,  8'd17,  32'hFFFF_0000, 1'b0, '0},
            '{16'd4439,  8'd1,   32'h0000_FFFF, 1'b0, '0},
            // largest legal datagram, then lengths above it
            '{16'd65515, 8'd255, 32'hFFFF_FFFF, 1'b0, '0},
            '{16'd65516, 8'd0,   32'h1234_5678, 1'b0, '0},
            '{16'd65535, 8'd255, 32'hFFFF_FFFF, 1'b0, '0},
            '{16'd65534, 8'd89,  32'h7F00_0001, 1'b0, '0},
            // exactly 44 full fragments, then 45 with a one-byte tail
            '{16'd65120, 8'd6,   32'hC633_6401, 1'b0, '0},
            '{16'd65121, 8'd17,  32'h0000_0000, 1'b0, '0},
            // empty payload with every other field at its top
            '{16'd0,     8'd255, 32'hFFFF_FFFF, 1'b0, '0}
        };

        // Drive every input to a known value before the first edge
        i_rst_n          <= 1'b0;
        psel             <= 1'b0;
        penable          <= 1'b0;
        pwrite           <= 1'b0;
        paddr            <= '0;
        pwdata           <= '0;
        i_valid          <= 1'b0;
        i_payload_length <= '0;
        i_protocol       <= '0;
        i_dest_ip        <= '0;
        mismatch_count   = 0;
        send_idle_pct    = 0;
        recv_idle_pct    = 0;
        shadow_src_ip    = 32'd0;
        shadow_ttl       = TTL_RESET;
        shadow_ident     = 16'd0;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Walk the table at the reset register values, no idling
        for (int r = 0; r < NUM_ROWS; r++)
            send_request(directed_rows[r].length, directed_rows[r].proto,
                         directed_rows[r].dst, directed_rows[r].typed,
                         directed_rows[r].want);
        i_valid <= 1'b0;
        drain(16);

        // All-ones registers; sender rarely idles, receiver stalls half the time
        set_register(REG_SOURCE_IP, 32'hFFFF_FFFF);
        set_register(REG_TTL, 32'd255);
        run_random(8, 49, 48);
        drain(16);

        // All-zero registers; roles of the two sides swapped
        set_register(REG_SOURCE_IP, 32'h0000_0000);
        set_register(REG_TTL, 32'd0);
        run_random(49, 8, 48);
        drain(16);

        // Random registers, both sides at full rate
        set_register(REG_SOURCE_IP, $urandom);
        set_register(REG_TTL, 32'($urandom_range(255)));
        run_random(0, 0, 48);

        // Hold for the longest request time before closing out
        drain(DRAIN_WAIT);
        if (expected_headers.size() != 0)
            flag_mismatch("headers never delivered", expected_headers.size(), 0);

        if (mismatch_count == 0)
            $display("ipv4_fragment_header_generator_tb: PASS");
        else
            $display("ipv4_fragment_header_generator_tb: FAIL");
        $finish;
    end

endmodule
